// ===== rtl/arm_block_transfer_sequencer_defines.svh =====
// Assertion macros shared by the block transfer sequencer RTL.
// Depends on nothing; the macros reduce to nothing when SYNTHESIS is defined.
`ifndef ARM_BLOCK_TRANSFER_SEQUENCER_DEFINES_SVH
`define ARM_BLOCK_TRANSFER_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define ABTS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication.
`define ABTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ABTS_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ABTS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/abts_pkg.sv =====
// Types, codes and helpers of the block transfer sequencer.
// Depends on nothing; used by arm_block_transfer_sequencer.
package abts_pkg;

   localparam logic [31:0] WORD_STEP = 32'd4;
   localparam logic [3:0]  LAST_GPR  = 4'd14;
   localparam logic [3:0]  PC_REG    = 4'd15;
   localparam logic [3:0]  SP_REG    = 4'd13;

   typedef enum logic [1:0] {
      MODE_IA = 2'd0,
      MODE_DA = 2'd1,
      MODE_DB = 2'd2,
      MODE_IB = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      OP_LOAD   = 3'd0,
      OP_STORE  = 3'd1,
      OP_WB     = 3'd2,
      OP_UNPRED = 3'd3,
      OP_SKIP   = 3'd4
   } op_kind_type;

   typedef enum logic [1:0] {
      HINT_NONE = 2'd0,
      HINT_RET  = 2'd1,
      HINT_POP  = 2'd2
   } hint_type;

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_SPAN    = 7'b0000010,
      S_START   = 7'b0000100,
      S_XFER    = 7'b0001000,
      S_WB      = 7'b0010000,
      S_PC      = 7'b0100000,
      S_SPECIAL = 7'b1000000
   } state_type;

   // Number of set bits in a register list.
   function automatic logic [4:0] list_count(input logic [15:0] v);
      logic [4:0] cnt;
      cnt = 5'd0;
      for (int i = 0; i < 16; i++) begin
         cnt = cnt + {4'b0, v[i]};
      end
      return cnt;
   endfunction

endpackage

// ===== rtl/arm_block_transfer_sequencer.sv =====
// Load/store-multiple address sequencer: top level, single module.
// Depends on abts_pkg and arm_block_transfer_sequencer_defines.svh.
`include "arm_block_transfer_sequencer_defines.svh"

// Takes one load- or store-multiple instruction per req_ item and emits its
// word transfers as rsp_ items: registers 0 to 14 of the list in ascending
// order four bytes apart, then the base writeback when it applies, then the
// PC transfer; rsp_last marks the final item of an instruction. A base of
// register 15 or an empty list yields one unpredictable item, a failed
// condition one skipped item. Addresses wrap at 32 bits. All address math
// runs through one shared 32-bit adder: it forms the writeback value first,
// then the start address, then each low-register transfer address (address
// plus four). An instruction passes through the steps accept, writeback
// value, start address, the low-register transfers, loop exit, writeback
// slot and, with the PC listed, PC slot; the special cases go from accept
// to their one item. req_ready is high only between instructions, one at a time. Results
// leave through an output register, so a new item may be taken while the
// last result of the previous one still waits on rsp_ready; backpressure on
// rsp_ holds back each item until the output register is free.
module arm_block_transfer_sequencer (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_action,
   input  abts_pkg::mode_type        req_mode,
   input  logic                      req_writeback,
   input  logic [3:0]                req_base_reg,
   input  logic [15:0]               req_register_list,
   input  logic [31:0]               req_base_value,
   input  logic [31:0]               req_pc_value,
   input  logic                      req_condition_passed,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output abts_pkg::op_kind_type     rsp_op_kind,
   output logic [31:0]               rsp_address,
   output logic [3:0]                rsp_reg_index,
   output logic [31:0]               rsp_value,
   output abts_pkg::hint_type        rsp_branch_hint,
   output logic                      rsp_last
);
   import abts_pkg::*;

   // Sequencer state and latched instruction.
   state_type   state_ff, state_in;
   logic        store_ff, store_in;
   mode_type    mode_ff, mode_in;
   logic        wb_need_ff, wb_need_in;
   logic [3:0]  base_ff, base_in;
   logic        pc_bit_ff, pc_bit_in;
   logic [31:0] base_value_ff, base_value_in;
   logic [31:0] pc_value_ff, pc_value_in;
   logic [4:0]  count_ff, count_in;
   logic [31:0] wb_value_ff, wb_value_in;
   logic [31:0] addr_ff, addr_in;
   logic [14:0] remain_ff, remain_in;
   op_kind_type special_ff, special_in;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   op_kind_type rsp_kind_ff, rsp_kind_in;
   logic [31:0] rsp_addr_ff, rsp_addr_in;
   logic [3:0]  rsp_reg_ff, rsp_reg_in;
   logic [31:0] rsp_value_ff, rsp_value_in;
   hint_type    rsp_hint_ff, rsp_hint_in;
   logic        rsp_last_ff, rsp_last_in;

   // Shared adder.
   logic [31:0] add_a, add_b, add_sum;
   logic        add_sub;

   logic        accept, out_free, emit, descending;
   logic [3:0]  low_idx;
   logic [14:0] remain_next;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign add_sum = add_a + (add_b ^ {32{add_sub}}) + {31'b0, add_sub};

   // Lowest pending register below the PC, and the list with it removed.
   always_comb begin
      low_idx = 4'd0;
      for (int i = 14; i >= 0; i--) begin
         if (remain_ff[i]) begin
            low_idx = 4'(i);
         end
      end
   end
   assign remain_next = remain_ff & (remain_ff - 15'd1);

   always_comb begin
      descending = mode_ff inside {MODE_DA, MODE_DB};
   end

   always_comb begin
      state_in      = state_ff;
      store_in      = store_ff;
      mode_in       = mode_ff;
      wb_need_in    = wb_need_ff;
      base_in       = base_ff;
      pc_bit_in     = pc_bit_ff;
      base_value_in = base_value_ff;
      pc_value_in   = pc_value_ff;
      count_in      = count_ff;
      wb_value_in   = wb_value_ff;
      addr_in       = addr_ff;
      remain_in     = remain_ff;
      special_in    = special_ff;

      add_a   = addr_ff;
      add_b   = WORD_STEP;
      add_sub = 1'b0;

      emit        = 1'b0;
      rsp_kind_in = rsp_kind_ff;
      rsp_addr_in = rsp_addr_ff;
      rsp_reg_in  = rsp_reg_ff;
      rsp_value_in = rsp_value_ff;
      rsp_hint_in = rsp_hint_ff;
      rsp_last_in = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               // Latch the instruction and pick the path.
               store_in      = req_action;
               mode_in       = req_mode;
               wb_need_in    = req_writeback &&
                               (req_action || !req_register_list[req_base_reg]);
               base_in       = req_base_reg;
               pc_bit_in     = req_register_list[PC_REG];
               base_value_in = req_base_value;
               pc_value_in   = req_pc_value;
               count_in      = list_count(req_register_list);
               remain_in     = req_register_list[14:0];
               if (req_base_reg == PC_REG || req_register_list == 16'd0) begin
                  special_in = OP_UNPRED;
                  state_in   = S_SPECIAL;
               end else if (!req_condition_passed) begin
                  special_in = OP_SKIP;
                  state_in   = S_SPECIAL;
               end else begin
                  state_in = S_SPAN;
               end
            end
         end
         S_SPAN: begin
            // Writeback value: base plus or minus four times the count.
            add_a       = base_value_ff;
            add_b       = {25'b0, count_ff, 2'b00};
            add_sub     = descending;
            wb_value_in = add_sum;
            state_in    = S_START;
         end
         S_START: begin
            // Start address derives from base (ascending) or writeback value.
            add_a    = descending ? wb_value_ff : base_value_ff;
            add_b    = (mode_ff == MODE_DA || mode_ff == MODE_IB) ? WORD_STEP : 32'd0;
            add_sub  = 1'b0;
            addr_in  = add_sum;
            state_in = S_XFER;
         end
         S_XFER: begin
            if (remain_ff == 15'd0) begin
               state_in = S_WB;
            end else if (out_free) begin
               emit         = 1'b1;
               rsp_kind_in  = store_ff ? OP_STORE : OP_LOAD;
               rsp_addr_in  = addr_ff;
               rsp_reg_in   = low_idx;
               rsp_value_in = 32'd0;
               rsp_hint_in  = HINT_NONE;
               rsp_last_in  = (remain_next == 15'd0) && !wb_need_ff && !pc_bit_ff;
               // Advance to the next word.
               add_a        = addr_ff;
               add_b        = WORD_STEP;
               add_sub      = 1'b0;
               addr_in      = add_sum;
               remain_in    = remain_next;
            end
         end
         S_WB: begin
            if (!wb_need_ff) begin
               state_in = pc_bit_ff ? S_PC : S_IDLE;
            end else if (out_free) begin
               emit         = 1'b1;
               rsp_kind_in  = OP_WB;
               rsp_addr_in  = 32'd0;
               rsp_reg_in   = base_ff;
               rsp_value_in = wb_value_ff;
               rsp_hint_in  = HINT_NONE;
               rsp_last_in  = !pc_bit_ff;
               state_in     = pc_bit_ff ? S_PC : S_IDLE;
            end
         end
         S_PC: begin
            if (out_free) begin
               emit         = 1'b1;
               rsp_kind_in  = store_ff ? OP_STORE : OP_LOAD;
               rsp_addr_in  = addr_ff;
               rsp_reg_in   = PC_REG;
               rsp_value_in = store_ff ? pc_value_ff : 32'd0;
               if (store_ff) begin
                  rsp_hint_in = HINT_NONE;
               end else begin
                  rsp_hint_in = (base_ff == SP_REG) ? HINT_POP : HINT_RET;
               end
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_SPECIAL: begin
            if (out_free) begin
               emit         = 1'b1;
               rsp_kind_in  = special_ff;
               rsp_addr_in  = 32'd0;
               rsp_reg_in   = 4'd0;
               rsp_value_in = 32'd0;
               rsp_hint_in  = HINT_NONE;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and datapath registers.
   always_ff @(posedge clock) begin
      store_ff      <= store_in;
      mode_ff       <= mode_in;
      wb_need_ff    <= wb_need_in;
      base_ff       <= base_in;
      pc_bit_ff     <= pc_bit_in;
      base_value_ff <= base_value_in;
      pc_value_ff   <= pc_value_in;
      count_ff      <= count_in;
      wb_value_ff   <= wb_value_in;
      addr_ff       <= addr_in;
      remain_ff     <= remain_in;
      special_ff    <= special_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_reg_ff    <= rsp_reg_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_hint_ff   <= rsp_hint_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_op_kind     = rsp_kind_ff;
   assign rsp_address     = rsp_addr_ff;
   assign rsp_reg_index   = rsp_reg_ff;
   assign rsp_value       = rsp_value_ff;
   assign rsp_branch_hint = rsp_hint_ff;
   assign rsp_last        = rsp_last_ff;

   // An accepted instruction always leaves idle.
   `ABTS_ASSERT_NEXT(a_accept_busy, clock, reset, accept, state_ff != S_IDLE)
   // The final result of an instruction is never followed at once by another.
   `ABTS_ASSERT_NEXT(a_last_pause, clock, reset, emit && rsp_last_in, !emit)
   // Writeback and PC slots come only after all low registers are sent.
   `ABTS_ASSERT_IMPLIES(a_wb_after_xfer, clock, reset, state_ff == S_WB, remain_ff == 15'd0)
   // The PC slot is reached only with the PC in the list.
   `ABTS_ASSERT_IMPLIES(a_pc_listed, clock, reset, state_ff == S_PC, pc_bit_ff)

endmodule
